### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising clock edge outside reset.
`define CHECK_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that an implication holds at the next rising clock edge.
`define CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### hw/rtl/tasc_pkg.sv
// Package for the three-axis step command controller: payload types, codes,
// command text table. No dependencies.
package tasc_pkg;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       step_x_on;
      logic       step_y_on;
      logic       step_z_on;
      logic       turn_on;
      logic       dir_x;
      logic       dir_y;
      logic       dir_z;
      logic       conveyor_on;
      logic       pickup_on;
      logic       busy_res;
      logic [2:0] event_res;
   } rsp_type;

   localparam logic [2:0] MODE_BYTE  = 3'd0;
   localparam logic [2:0] MODE_TICKA = 3'd1;
   localparam logic [2:0] MODE_TICKB = 3'd2;
   localparam logic [2:0] MODE_LIMX  = 3'd3;
   localparam logic [2:0] MODE_LIMY  = 3'd4;
   localparam logic [2:0] MODE_LIMZ  = 3'd5;
   localparam logic [2:0] MODE_ESTOP = 3'd6;

   localparam logic [2:0] EV_NONE   = 3'd0;
   localparam logic [2:0] EV_MOVE   = 3'd1;
   localparam logic [2:0] EV_CMD    = 3'd2;
   localparam logic [2:0] EV_REJECT = 3'd3;
   localparam logic [2:0] EV_DONE   = 3'd4;
   localparam logic [2:0] EV_HOMED  = 3'd5;

   // Command codes, lowest code wins when several match.
   localparam logic [2:0] CMD_HOME       = 3'd0;
   localparam logic [2:0] CMD_STOP       = 3'd1;
   localparam logic [2:0] CMD_TURN       = 3'd2;
   localparam logic [2:0] CMD_STOP_CONV  = 3'd3;
   localparam logic [2:0] CMD_START_CONV = 3'd4;
   localparam logic [2:0] CMD_START_PICK = 3'd5;
   localparam logic [2:0] CMD_STOP_PICK  = 3'd6;

   typedef enum logic [1:0] {
      RUN_IDLE = 2'd0,
      RUN_MOVE = 2'd1,
      RUN_TURN = 2'd2,
      RUN_HOME = 2'd3
   } run_type;

   localparam int CMD_LEN = 26;
   localparam int AXIS_W  = 20;

   // Command text, padding '-', position CMD_LEN reads zero.
   function automatic logic [7:0] cmd_char(input logic [2:0] k, input logic [4:0] pos);
      logic [8*26-1:0] s;
      begin
         case (k)
            CMD_HOME:       s = "Home----------------------";
            CMD_STOP:       s = "Stop----------------------";
            CMD_TURN:       s = "Turn Around---------------";
            CMD_STOP_CONV:  s = "Stop conveyor-------------";
            CMD_START_CONV: s = "Start conveyor------------";
            CMD_START_PICK: s = "Start pick up-------------";
            default:        s = "Stop pick up--------------";
         endcase
         if (pos >= 5'(CMD_LEN)) begin
            cmd_char = 8'd0;
         end else begin
            cmd_char = s[8*(25 - int'(pos)) +: 8];
         end
      end
   endfunction

   // Weight of a digit place, counted from the least significant.
   function automatic logic [16:0] place_weight(input logic [2:0] i);
      begin
         case (i)
            3'd0: place_weight = 17'd1;
            3'd1: place_weight = 17'd10;
            3'd2: place_weight = 17'd100;
            3'd3: place_weight = 17'd1000;
            3'd4: place_weight = 17'd10000;
            3'd5: place_weight = 17'd100000;
            default: place_weight = 17'd0;
         endcase
      end
   endfunction

   // Frame outcome passed from front to back.
   typedef struct packed {
      logic              is_frame;   // frame end: run command or move
      logic              is_cmd;
      logic [2:0]        cmd;
      logic [2:0]        minus;
      logic [2:0]        used;
      logic [3*AXIS_W-1:0] target;
      logic [2:0]        mode;
   } job_type;

endpackage

### hw/rtl/three_axis_step_command_controller.sv
// Three-axis step command controller, top level.
// Depends on tasc_pkg, tasc_front, tasc_fifo, tasc_back, assert_macros.svh.
//
// Every accepted beat (frame byte, tick, limit, e-stop) yields exactly one
// result beat showing the drive, direction and relay state after it plus an
// event code. One beat per cycle is sustained while the queues have room:
// the front end parses and matches frame bytes combinationally, a two-entry
// job queue decouples it from the back end, and the back end updates run
// state and counters into a two-entry result queue. full rises only when
// both queues fill under backpressure. turn_count_ff is written through
// csr_; the user must write it only while the block is idle, which the block does not enforce.
module three_axis_step_command_controller #(
   parameter int FRAME_BYTES  = 26,
   parameter int FIELD_DIGITS = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  tasc_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output tasc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);
   import tasc_pkg::*;
`include "assert_macros.svh"

   logic [15:0] turn_count_ff;
   logic        accept;
   job_type     job_w, job_r;
   logic        q_empty, q_take;

   assign accept = push && !full;

   // Hold the turn length register.
   always_ff @(posedge clock) begin
      if (reset) turn_count_ff <= 16'd3200;
      else if (csr_we) turn_count_ff <= csr_wdata;
   end

   tasc_front #(.FRAME_BYTES(FRAME_BYTES), .FIELD_DIGITS(FIELD_DIGITS)) u_front (
      .clock(clock), .reset(reset), .in_valid(accept), .in_req(req_data), .job(job_w)
   );

   tasc_fifo u_fifo (
      .clock(clock), .reset(reset), .wr_en(accept), .wr_data(job_w), .full(full),
      .rd_en(q_take), .rd_data(job_r), .empty(q_empty)
   );

   tasc_back u_back (
      .clock(clock), .reset(reset), .turn_count(turn_count_ff),
      .job_valid(!q_empty), .job(job_r), .job_take(q_take),
      .rsp_data(rsp_data), .rsp_empty(empty), .rsp_pop(pop)
   );

   `CHECK_ALWAYS(a_take_needs_job, clock, reset, !(q_take && q_empty), "take from empty queue")
   `CHECK_NEXT(a_push_fills, clock, reset, accept && q_empty && !q_take, !q_empty, "job lost")
endmodule

### hw/rtl/tasc_front.sv
// Front end: frame matching and decimal parsing, one item per cycle.
// Depends on tasc_pkg.
module tasc_front #(
   parameter int FRAME_BYTES  = 26,
   parameter int FIELD_DIGITS = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  tasc_pkg::req_type in_req,
   output tasc_pkg::job_type job
);
   import tasc_pkg::*;

   logic [4:0]  pos_ff, pos_in;
   logic [6:0]  match_ff, match_in;
   logic [1:0]  fld_ff, fld_in;
   logic [2:0]  place_ff [3];
   logic [2:0]  place_in [3];
   logic [2:0]  minus_ff, minus_in;
   logic [AXIS_W-1:0] val_ff [3];
   logic [AXIS_W-1:0] val_in [3];
   logic        last;
   logic [7:0]  b;
   logic [2:0]  p;
   logic [AXIS_W-1:0] addv;

   assign b = in_req.rx_byte;
   assign last = (32'(pos_ff) + 1) >= FRAME_BYTES;

   always_comb begin
      pos_in = pos_ff; match_in = match_ff; fld_in = fld_ff; minus_in = minus_ff;
      for (int a = 0; a < 3; a++) begin
         place_in[a] = place_ff[a];
         val_in[a] = val_ff[a];
      end
      p = 3'd0; addv = '0;
      if (in_valid && in_req.mode == MODE_BYTE) begin
         if (pos_ff <= 5'(CMD_LEN)) begin
            for (int k = 0; k < 7; k++) begin
               if (b != cmd_char(3'(k), pos_ff)) match_in[k] = 1'b0;
            end
         end
         if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "=") begin
            // skip
         end else if (b == ",") begin
            if (fld_ff < 2'd3) fld_in = fld_ff + 2'd1;
         end else if (fld_ff != 2'd3) begin
            p = place_ff[fld_ff];
            if (b == "-") begin
               minus_in[fld_ff] = 1'b1;
            end else if (b >= "0" && b <= "9" && 32'(p) < FIELD_DIGITS) begin
               addv = AXIS_W'(32'(b - "0") * 32'(place_weight(3'(FIELD_DIGITS - 1 - int'(p)))));
               val_in[fld_ff] = val_ff[fld_ff] + addv;
            end
            if (p < 3'd7) place_in[fld_ff] = p + 3'd1;
         end
         if (last) begin
            pos_in = '0; match_in = 7'h7F; fld_in = '0; minus_in = '0;
            for (int a = 0; a < 3; a++) begin
               place_in[a] = '0; val_in[a] = '0;
            end
         end else begin
            pos_in = pos_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; match_ff <= 7'h7F; fld_ff <= '0; minus_ff <= '0;
         for (int a = 0; a < 3; a++) begin
            place_ff[a] <= '0; val_ff[a] <= '0;
         end
      end else begin
         pos_ff <= pos_in; match_ff <= match_in; fld_ff <= fld_in; minus_ff <= minus_in;
         for (int a = 0; a < 3; a++) begin
            place_ff[a] <= place_in[a]; val_ff[a] <= val_in[a];
         end
      end
   end

   // Build the job from the values after this byte (pre-clear).
   logic [6:0]  mfin;
   logic [2:0]  mfin_minus;
   logic [AXIS_W-1:0] vfin [3];
   logic [2:0]  pfin [3];
   always_comb begin
      mfin = match_ff; mfin_minus = minus_ff;
      for (int a = 0; a < 3; a++) begin
         vfin[a] = val_ff[a]; pfin[a] = place_ff[a];
      end
      if (pos_ff <= 5'(CMD_LEN)) begin
         for (int k = 0; k < 7; k++) begin
            if (b != cmd_char(3'(k), pos_ff)) mfin[k] = 1'b0;
         end
      end
      if (!((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "=") && b != ","
          && fld_ff != 2'd3) begin
         if (b == "-") mfin_minus[fld_ff] = 1'b1;
         vfin[fld_ff] = val_ff[fld_ff] + addv;
         if (place_ff[fld_ff] < 3'd7) pfin[fld_ff] = place_ff[fld_ff] + 3'd1;
      end
      job = '0;
      job.mode = in_req.mode;
      job.is_frame = (in_req.mode == MODE_BYTE) && last;
      job.is_cmd = |mfin;
      job.cmd = CMD_STOP_PICK;
      for (int k = 6; k >= 0; k--) begin
         if (mfin[k]) job.cmd = 3'(k);
      end
      job.minus = mfin_minus;
      for (int a = 0; a < 3; a++) begin
         job.used[a] = pfin[a] != 3'd0;
         job.target[a*AXIS_W +: AXIS_W] = vfin[a];
      end
   end
endmodule

### hw/rtl/tasc_fifo.sv
// Small queue of jobs between front and back ends.
// Depends on tasc_pkg.
module tasc_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  tasc_pkg::job_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output tasc_pkg::job_type rd_data,
   output logic              empty
);
   import tasc_pkg::*;

   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= ~wp_ff;
         if (rd_en) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(wr_en) - 2'(rd_en);
      end
   end
endmodule

### hw/rtl/tasc_back.sv
// Back end: run state, axis counters, relays and the result queue.
// Depends on tasc_pkg.
module tasc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [15:0]       turn_count,
   input  logic              job_valid,
   input  tasc_pkg::job_type job,
   output logic              job_take,
   output tasc_pkg::rsp_type rsp_data,
   output logic              rsp_empty,
   input  logic              rsp_pop
);
   import tasc_pkg::*;

   run_type     run_ff, run_in;
   logic [8:0]  ob_ff, ob_in;
   logic [2:0]  homed_ff, homed_in;
   logic [15:0] tcnt_ff, tcnt_in;
   logic [AXIS_W-1:0] tgt_ff [3];
   logic [AXIS_W-1:0] tgt_in [3];
   logic [AXIS_W-1:0] cnt_ff [3];
   logic [AXIS_W-1:0] cnt_in [3];
   logic [2:0]  ev;
   logic [2:0]  lim;
   logic        all_done;

   rsp_type    q_ff [2];
   logic       qw_ff, qr_ff;
   logic [1:0] qn_ff;

   assign job_take = job_valid && qn_ff != 2'd2;

   always_comb begin
      run_in = run_ff; ob_in = ob_ff; homed_in = homed_ff; tcnt_in = tcnt_ff;
      for (int a = 0; a < 3; a++) begin
         tgt_in[a] = tgt_ff[a]; cnt_in[a] = cnt_ff[a];
      end
      ev = EV_NONE; lim = '0; all_done = 1'b1;
      case (job.mode)
         MODE_BYTE: begin
            if (job.is_frame) begin
               if (run_ff != RUN_IDLE) begin
                  ev = EV_REJECT;
               end else if (job.is_cmd) begin
                  ev = EV_CMD;
                  case (job.cmd)
                     CMD_HOME: begin
                        ob_in[6:4] = 3'b111; ob_in[2:0] = 3'b111; run_in = RUN_HOME;
                     end
                     CMD_STOP: begin ob_in[2:0] = '0; ob_in[7] = 1'b0; end
                     CMD_TURN: begin
                        ob_in[7] = 1'b1; ob_in[2:0] = '0; ob_in[3] = 1'b1;
                        tcnt_in = '0; run_in = RUN_TURN;
                     end
                     CMD_STOP_CONV: ob_in[7] = 1'b0;
                     CMD_START_CONV: ob_in[7] = 1'b1;
                     CMD_START_PICK: ob_in[8] = 1'b1;
                     default: ob_in[8] = 1'b0;
                  endcase
               end else begin
                  ev = EV_MOVE;
                  run_in = RUN_IDLE;
                  for (int a = 0; a < 3; a++) begin
                     if (job.minus[a]) ob_in[4+a] = 1'b1;
                     else if (job.used[a]) ob_in[4+a] = 1'b0;
                     tgt_in[a] = job.target[a*AXIS_W +: AXIS_W];
                     cnt_in[a] = '0;
                     ob_in[a] = tgt_in[a] != '0;
                     if (tgt_in[a] != '0) run_in = RUN_MOVE;
                  end
               end
            end
         end
         MODE_TICKA, MODE_TICKB: begin
            if (run_ff == RUN_MOVE) begin
               for (int a = 0; a < 3; a++) begin
                  if (((job.mode == MODE_TICKA) != (a == 1)) && cnt_ff[a] < tgt_ff[a]) begin
                     cnt_in[a] = cnt_ff[a] + AXIS_W'(1);
                     if (cnt_in[a] >= tgt_ff[a]) ob_in[a] = 1'b0;
                  end
                  if (cnt_in[a] < tgt_ff[a]) all_done = 1'b0;
               end
               if (all_done) begin run_in = RUN_IDLE; ev = EV_DONE; end
            end else if (run_ff == RUN_TURN && job.mode == MODE_TICKA) begin
               tcnt_in = tcnt_ff + 16'd1;
               if (tcnt_in >= turn_count) begin
                  ob_in[3] = 1'b0; tcnt_in = '0; run_in = RUN_IDLE; ev = EV_DONE;
               end
            end
         end
         MODE_LIMX, MODE_LIMY, MODE_LIMZ: begin
            lim = (job.mode == MODE_LIMX) ? 3'b001 :
                  (job.mode == MODE_LIMY) ? 3'b010 : 3'b100;
            ob_in[2:0] = ob_ff[2:0] & ~lim;
            homed_in = homed_ff | lim;
            if (homed_in == 3'b111) begin
               homed_in = '0; ob_in[7] = 1'b1; ev = EV_HOMED;
               if (run_ff == RUN_HOME) run_in = RUN_IDLE;
            end
         end
         MODE_ESTOP: begin
            ob_in[2:0] = '0;
            if (run_ff == RUN_MOVE || run_ff == RUN_HOME) run_in = RUN_IDLE;
         end
         default: ;
      endcase
   end

   rsp_type r;
   always_comb begin
      r.step_x_on = ob_in[0]; r.step_y_on = ob_in[1]; r.step_z_on = ob_in[2];
      r.turn_on = ob_in[3]; r.dir_x = ob_in[4]; r.dir_y = ob_in[5]; r.dir_z = ob_in[6];
      r.conveyor_on = ob_in[7]; r.pickup_on = ob_in[8];
      r.busy_res = run_in != RUN_IDLE; r.event_res = ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= RUN_IDLE; ob_ff <= '0; homed_ff <= '0; tcnt_ff <= '0;
         for (int a = 0; a < 3; a++) begin
            tgt_ff[a] <= '0; cnt_ff[a] <= '0;
         end
      end else if (job_take) begin
         run_ff <= run_in; ob_ff <= ob_in; homed_ff <= homed_in; tcnt_ff <= tcnt_in;
         for (int a = 0; a < 3; a++) begin
            tgt_ff[a] <= tgt_in[a]; cnt_ff[a] <= cnt_in[a];
         end
      end
   end

   logic pop_ok;
   assign pop_ok = rsp_pop && qn_ff != 2'd0;
   assign rsp_empty = qn_ff == 2'd0;
   assign rsp_data = q_ff[qr_ff];

   always_ff @(posedge clock) begin
      if (job_take) q_ff[qw_ff] <= r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qw_ff <= 1'b0; qr_ff <= 1'b0; qn_ff <= '0;
      end else begin
         if (job_take) qw_ff <= ~qw_ff;
         if (pop_ok) qr_ff <= ~qr_ff;
         qn_ff <= qn_ff + 2'(job_take) - 2'(pop_ok);
      end
   end
endmodule

### dv/three_axis_step_command_controller_tb.sv
// Self-checking testbench for three_axis_step_command_controller: directed table, then random
// frames, ticks, limits and e-stops checked against an in-bench predictor.
// Depends on tasc_pkg and the controller RTL.
`timescale 1ns / 1ps

module three_axis_step_command_controller_tb;
   import tasc_pkg::*;

   localparam int FRAME_LEN   = 26;
   localparam int PLACES      = 6;
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_WAIT  = 10;

   // Command indexes, in priority order of the match.
   localparam int CMD_HOME       = 0;
   localparam int CMD_STOP       = 1;
   localparam int CMD_TURN       = 2;
   localparam int CMD_STOP_CONV  = 3;
   localparam int CMD_START_CONV = 4;
   localparam int CMD_START_PICK = 5;
   localparam int CMD_STOP_PICK  = 6;
   localparam int NUM_CMDS       = 7;

   // Bit positions in the relay/drive image.
   localparam int TURN_BIT = 3;
   localparam int DIR_BIT  = 4;
   localparam int CONV_BIT = 7;
   localparam int PICK_BIT = 8;

   localparam logic [7:0] FILL_CHAR = 8'h51;   // 'Q', skipped by the number parser
   localparam logic [2:0] MODE_SPARE = 3'd7;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   req_type     req_data;
   logic        empty;
   logic        pop;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [15:0] csr_wdata;

   three_axis_step_command_controller u_top (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // ---------------------------------------------------------------------------------------------
   // Predictor state: parser, run control, counters and the output image.
   // ---------------------------------------------------------------------------------------------
   string        cmd_str [NUM_CMDS];
   int           frame_pos;
   logic [6:0]   cmd_hits;
   int           fld;
   int           places [3];
   logic         neg [3];
   logic [19:0]  acc [3];
   logic [19:0]  goal [3];
   logic [19:0]  done_cnt [3];
   logic [15:0]  turn_cnt;
   logic [15:0]  turn_limit;
   run_type      run;
   logic [2:0]   homed;
   logic [8:0]   drive_reg;

   rsp_type      pending_results [$];
   int           beats_sent;
   int           mismatches;
   int           send_idle;
   int           recv_idle;

   function automatic void clear_frame();
      frame_pos = 0;
      cmd_hits  = '1;
      fld       = 0;
      for (int a = 0; a < 3; a++) begin
         places[a] = 0;
         neg[a]    = 1'b0;
         acc[a]    = '0;
      end
   endfunction

   function automatic logic [19:0] weight_of(int p);
      logic [19:0] w;
      w = 20'd1;
      for (int i = 0; i < PLACES - 1 - p; i++) w = w * 20'd10;
      return w;
   endfunction

   function automatic void parse_char(logic [7:0] b);
      int p;
      if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "=") return;
      if (b == ",") begin
         if (fld < 3) fld++;
         return;
      end
      if (fld > 2) return;
      p = places[fld];
      if (b == "-") begin
         neg[fld] = 1'b1;
      end else if (b >= "0" && b <= "9" && p < PLACES) begin
         acc[fld] = acc[fld] + 20'(b - "0") * weight_of(p);
      end
      if (p < 7) places[fld] = p + 1;
   endfunction

   function automatic logic [2:0] run_command(int k);
      case (k)
         CMD_HOME: begin
            drive_reg[DIR_BIT +: 3] = 3'b111;
            drive_reg[2:0] = 3'b111;
            run = RUN_HOME;
         end
         CMD_STOP: begin
            drive_reg[2:0] = 3'b000;
            drive_reg[CONV_BIT] = 1'b0;
         end
         CMD_TURN: begin
            drive_reg[CONV_BIT] = 1'b1;
            drive_reg[2:0] = 3'b000;
            drive_reg[TURN_BIT] = 1'b1;
            turn_cnt = '0;
            run = RUN_TURN;
         end
         CMD_STOP_CONV:  drive_reg[CONV_BIT] = 1'b0;
         CMD_START_CONV: drive_reg[CONV_BIT] = 1'b1;
         CMD_START_PICK: drive_reg[PICK_BIT] = 1'b1;
         default:        drive_reg[PICK_BIT] = 1'b0;
      endcase
      return EV_CMD;
   endfunction

   function automatic logic [2:0] launch_move();
      logic any;
      any = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (neg[a]) drive_reg[DIR_BIT + a] = 1'b1;
         else if (places[a] != 0) drive_reg[DIR_BIT + a] = 1'b0;
         goal[a]      = acc[a];
         done_cnt[a]  = '0;
         drive_reg[a] = (acc[a] != 0);
         if (acc[a] != 0) any = 1'b1;
      end
      run = any ? RUN_MOVE : RUN_IDLE;
      return EV_MOVE;
   endfunction

   function automatic logic [2:0] take_byte(logic [7:0] b);
      int          k;
      logic [2:0]  ev;
      for (k = 0; k < NUM_CMDS; k++)
         if (b != cmd_str[k][frame_pos]) cmd_hits[k] = 1'b0;
      parse_char(b);
      if (frame_pos + 1 < FRAME_LEN) begin
         frame_pos++;
         return EV_NONE;
      end
      if (run != RUN_IDLE) begin
         ev = EV_REJECT;
      end else begin
         for (k = 0; k < NUM_CMDS; k++)
            if (cmd_hits[k]) break;
         ev = (k < NUM_CMDS) ? run_command(k) : launch_move();
      end
      clear_frame();
      return ev;
   endfunction

   function automatic void count_axis(int a);
      if (done_cnt[a] < goal[a]) begin
         done_cnt[a]++;
         if (done_cnt[a] >= goal[a]) drive_reg[a] = 1'b0;
      end
   endfunction

   function automatic logic [2:0] move_finished();
      for (int a = 0; a < 3; a++)
         if (done_cnt[a] < goal[a]) return EV_NONE;
      run = RUN_IDLE;
      return EV_DONE;
   endfunction

   function automatic logic [2:0] limit_event(int a);
      drive_reg[a] = 1'b0;
      homed[a] = 1'b1;
      if (homed != 3'b111) return EV_NONE;
      homed = '0;
      drive_reg[CONV_BIT] = 1'b1;
      if (run == RUN_HOME) run = RUN_IDLE;
      return EV_HOMED;
   endfunction

   // Advance the predictor by one accepted beat, return the result it owes.
   function automatic rsp_type controller_step(logic [2:0] mode, logic [7:0] b);
      logic [2:0] ev;
      rsp_type    r;
      ev = EV_NONE;
      case (mode)
         MODE_BYTE: ev = take_byte(b);
         MODE_TICKA: begin
            if (run == RUN_MOVE) begin
               count_axis(0);
               count_axis(2);
               ev = move_finished();
            end else if (run == RUN_TURN) begin
               turn_cnt++;
               if (turn_cnt >= turn_limit) begin
                  drive_reg[TURN_BIT] = 1'b0;
                  turn_cnt = '0;
                  run = RUN_IDLE;
                  ev = EV_DONE;
               end
            end
         end
         MODE_TICKB: begin
            if (run == RUN_MOVE) begin
               count_axis(1);
               ev = move_finished();
            end
         end
         MODE_LIMX, MODE_LIMY, MODE_LIMZ: ev = limit_event(int'(mode - MODE_LIMX));
         MODE_ESTOP: begin
            drive_reg[2:0] = 3'b000;
            if (run == RUN_MOVE || run == RUN_HOME) run = RUN_IDLE;
         end
         default: ;
      endcase
      r.step_x_on   = drive_reg[0];
      r.step_y_on   = drive_reg[1];
      r.step_z_on   = drive_reg[2];
      r.turn_on     = drive_reg[TURN_BIT];
      r.dir_x       = drive_reg[DIR_BIT];
      r.dir_y       = drive_reg[DIR_BIT + 1];
      r.dir_z       = drive_reg[DIR_BIT + 2];
      r.conveyor_on = drive_reg[CONV_BIT];
      r.pickup_on   = drive_reg[PICK_BIT];
      r.busy_res    = (run != RUN_IDLE);
      r.event_res   = ev;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------------
   // Sender: one beat per call, driven at the falling edge, accepted at a rising edge.
   // A typed expectation, when given, replaces the predicted one for that beat.
   // ---------------------------------------------------------------------------------------------
   task automatic send_beat(logic [2:0] mode, logic [7:0] b, bit use_typed = 1'b0,
                            rsp_type typed = '0);
      rsp_type predicted;
      while (send_idle != 0 && $urandom_range(99) < send_idle) begin
         push = 1'b0;
         @(negedge clock);
      end
      push = 1'b1;
      req_data.mode    = mode;
      req_data.rx_byte = b;
      @(posedge clock);
      while (full) @(posedge clock);
      predicted = controller_step(mode, b);
      pending_results.push_back(use_typed ? typed : predicted);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(string s, bit use_typed = 1'b0, rsp_type typed = '0);
      for (int i = 0; i < s.len(); i++)
         send_beat(MODE_BYTE, s[i], use_typed && i == s.len() - 1, typed);
   endtask

   // Hold off until every owed result has come back, then write the turn length.
   task automatic write_turn_length(logic [15:0] v);
      push = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we    = 1'b0;
      turn_limit = v;
   endtask

   // ---------------------------------------------------------------------------------------------
   // Receiver: pop at random, check every accepted result beat.
   // ---------------------------------------------------------------------------------------------
   always @(negedge clock) begin
      pop = (recv_idle == 0) ? 1'b1 : ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result beat %h", rsp_data);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.step_x_on !== want.step_x_on || rsp_data.step_y_on !== want.step_y_on ||
                rsp_data.step_z_on !== want.step_z_on || rsp_data.turn_on !== want.turn_on ||
                rsp_data.dir_x !== want.dir_x || rsp_data.dir_y !== want.dir_y ||
                rsp_data.dir_z !== want.dir_z || rsp_data.conveyor_on !== want.conveyor_on ||
                rsp_data.pickup_on !== want.pickup_on || rsp_data.busy_res !== want.busy_res ||
                rsp_data.event_res !== want.event_res) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("result mismatch: expected %p actual %p", want, rsp_data);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------------
   // Random episodes.
   // ---------------------------------------------------------------------------------------------
   function automatic string random_move_frame();
      string s;
      int    v;
      logic [7:0] c;
      s = "";
      for (int a = 0; a < 3; a++) begin
         v = ($urandom_range(7) == 0) ? $urandom_range(300) : $urandom_range(12);
         if ($urandom_range(3) == 0) s = {s, "-", $sformatf("%05d", v)};
         else s = {s, $sformatf("%06d", v)};
         if (a < 2) s = {s, ","};
      end
      // Drop in a stray byte now and then; it reads as digit zero.
      if ($urandom_range(5) == 0) begin
         c = 8'(1 + $urandom_range(42));
         if (c != ",") s[$urandom_range(s.len() - 1)] = c;
      end
      while (s.len() < FRAME_LEN)
         s = {s, ($urandom_range(4) == 0) ? "=" : string'(8'(65 + $urandom_range(25)))};
      return s;
   endfunction

   // Finish a partial frame and bring the block back to idle.
   task automatic settle();
      while (frame_pos != 0) send_beat(MODE_BYTE, FILL_CHAR);
      if (run == RUN_MOVE || run == RUN_HOME) send_beat(MODE_ESTOP, 8'($urandom));
      while (run == RUN_TURN) send_beat(MODE_TICKA, 8'($urandom));
   endtask

   task automatic random_phase(int stop_at, bit turns_ok);
      int sel;
      int r;
      int k;
      int n;
      while (beats_sent < stop_at) begin
         settle();
         sel = $urandom_range(99);
         if (sel < 45) begin
            send_frame(random_move_frame());
            while (run == RUN_MOVE) begin
               r = $urandom_range(99);
               if (r < 45) send_beat(MODE_TICKA, 8'($urandom));
               else if (r < 90) send_beat(MODE_TICKB, 8'($urandom));
               else if (r < 94) send_beat(3'(MODE_LIMX + $urandom_range(2)), 8'($urandom));
               else if (r < 96) send_beat(MODE_SPARE, 8'($urandom));
               else if (r < 98) send_frame(cmd_str[$urandom_range(NUM_CMDS - 1)]);
               else send_beat(MODE_ESTOP, 8'($urandom));
            end
         end else if (sel < 75) begin
            k = $urandom_range(NUM_CMDS - 1);
            if (!turns_ok && k == CMD_TURN) k = CMD_STOP_CONV;
            send_frame(cmd_str[k]);
            while (run == RUN_HOME) begin
               r = $urandom_range(99);
               if (r < 75) send_beat(3'(MODE_LIMX + $urandom_range(2)), 8'($urandom));
               else if (r < 90) send_beat(3'(MODE_TICKA + $urandom_range(1)), 8'($urandom));
               else if (r < 96) send_beat(MODE_SPARE, 8'($urandom));
               else send_beat(MODE_ESTOP, 8'($urandom));
            end
            while (run == RUN_TURN) begin
               r = $urandom_range(99);
               if (r < 85) send_beat(MODE_TICKA, 8'($urandom));
               else if (r < 90) send_beat(MODE_TICKB, 8'($urandom));
               else if (r < 95) send_beat(3'(MODE_LIMX + $urandom_range(2)), 8'($urandom));
               else send_beat(MODE_ESTOP, 8'($urandom));
            end
         end else if (sel < 88) begin
            n = 1 + $urandom_range(4);
            repeat (n) send_beat(3'($urandom), 8'($urandom));
         end else begin
            // Broken frame: each byte is either the command's byte at that place or random.
            n = 1 + $urandom_range(FRAME_LEN - 2);
            k = $urandom_range(NUM_CMDS - 1);
            for (int i = 0; i < n; i++)
               send_beat(MODE_BYTE, ($urandom_range(1) == 0) ? cmd_str[k][i] : 8'($urandom));
         end
      end
      settle();
   endtask

   // ---------------------------------------------------------------------------------------------
   // Directed table.
   // ---------------------------------------------------------------------------------------------
   typedef struct {
      logic [2:0] mode;
      string      text;     // frame bytes for a byte row
      int         reps;     // repeat count for a non-byte row
      bit         typed;
      rsp_type    want;     // checked on the row's last beat when typed
   } stim_row;

   stim_row table_rows [$];

   function automatic void add_row(logic [2:0] mode, string text, int reps, bit typed,
                                   rsp_type want = '0);
      stim_row r;
      r.mode  = mode;
      r.text  = text;
      r.reps  = reps;
      r.typed = typed;
      r.want  = want;
      table_rows.push_back(r);
   endfunction

   initial begin
      #2_000_000;
      $display("three_axis_step_command_controller_tb failed");
      $finish;
   end

   initial begin
      cmd_str[CMD_HOME]       = "Home----------------------";
      cmd_str[CMD_STOP]       = "Stop----------------------";
      cmd_str[CMD_TURN]       = "Turn Around---------------";
      cmd_str[CMD_STOP_CONV]  = "Stop conveyor-------------";
      cmd_str[CMD_START_CONV] = "Start conveyor------------";
      cmd_str[CMD_START_PICK] = "Start pick up-------------";
      cmd_str[CMD_STOP_PICK]  = "Stop pick up--------------";

      reset      = 1'b1;
      push       = 1'b0;
      req_data   = '0;
      pop        = 1'b0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      send_idle  = 10;
      recv_idle  = 82;
      beats_sent = 0;
      mismatches = 0;

      clear_frame();
      for (int a = 0; a < 3; a++) begin
         goal[a]     = '0;
         done_cnt[a] = '0;
      end
      turn_cnt   = '0;
      turn_limit = 16'd3200;
      run        = RUN_IDLE;
      homed      = '0;
      drive_reg  = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Idle ticks, relay commands, an extreme move with a stop rejected during it, an e-stop, homing,
      // a turn, odd parses and a zero move. Field order: x y z turn dx dy dz conv pick busy event.
      add_row(MODE_TICKA, "", 1, 1, '{0,0,0,0,0,0,0,0,0,0,EV_NONE});
      add_row(MODE_TICKB, "", 1, 1, '{0,0,0,0,0,0,0,0,0,0,EV_NONE});
      add_row(MODE_SPARE, "", 1, 1, '{0,0,0,0,0,0,0,0,0,0,EV_NONE});
      add_row(MODE_BYTE, "Start conveyor------------", 0, 1, '{0,0,0,0,0,0,0,1,0,0,EV_CMD});
      add_row(MODE_BYTE, "Start pick up-------------", 0, 1, '{0,0,0,0,0,0,0,1,1,0,EV_CMD});
      add_row(MODE_BYTE, "Stop pick up--------------", 0, 1, '{0,0,0,0,0,0,0,1,0,0,EV_CMD});
      add_row(MODE_BYTE, "Stop conveyor-------------", 0, 1, '{0,0,0,0,0,0,0,0,0,0,EV_CMD});
      add_row(MODE_BYTE, "-99999,999999,999999AAAAAA", 0, 1, '{1,1,1,0,1,0,0,0,0,1,EV_MOVE});
      add_row(MODE_BYTE, "Stop----------------------", 0, 0);
      add_row(MODE_ESTOP, "", 1, 0);
      add_row(MODE_BYTE, "Home----------------------", 0, 1, '{1,1,1,0,1,1,1,0,0,1,EV_CMD});
      add_row(MODE_LIMX, "", 1, 0);
      add_row(MODE_LIMY, "", 2, 0);
      add_row(MODE_LIMZ, "", 1, 1, '{0,0,0,0,1,1,1,1,0,0,EV_HOMED});
      add_row(MODE_BYTE, "Turn Around---------------", 0, 0);
      add_row(MODE_TICKB, "", 1, 0);
      add_row(MODE_TICKA, "", 5, 0);
      add_row(MODE_BYTE, "X=12#4567,-0000002,000003Q", 0, 0);
      add_row(MODE_ESTOP, "", 1, 0);
      add_row(MODE_BYTE, "000002,000001,000001AAAAAA", 0, 0);
      add_row(MODE_TICKA, "", 2, 0);
      add_row(MODE_TICKB, "", 1, 0);
      add_row(MODE_BYTE, "0,0,0,,,9999999ABCDEFGHIJK", 0, 0);
      add_row(MODE_BYTE, "000000,000000,000000======", 0, 0);
      add_row(MODE_BYTE, "Stop----------------------", 0, 0);

      write_turn_length(16'd5);
      foreach (table_rows[i]) begin
         if (table_rows[i].mode == MODE_BYTE) begin
            send_frame(table_rows[i].text, table_rows[i].typed, table_rows[i].want);
         end else begin
            for (int j = 0; j < table_rows[i].reps; j++)
               send_beat(table_rows[i].mode, 8'($urandom),
                         table_rows[i].typed && j == table_rows[i].reps - 1, table_rows[i].want);
         end
      end

      // Shortest turn, sender mostly busy, receiver mostly stalled.
      write_turn_length(16'd1);
      random_phase(beats_sent + 350, 1'b1);

      // Longest turn: keep turn commands out, swap the idling.
      send_idle = 82;
      recv_idle = 10;
      write_turn_length(16'hFFFF);
      random_phase(beats_sent + 350, 1'b0);

      // Short random turn, no idling on either side.
      send_idle = 0;
      recv_idle = 0;
      write_turn_length(16'(2 + $urandom_range(58)));
      random_phase(beats_sent + 350, 1'b1);

      push = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      if (mismatches == 0) begin
         $display("three_axis_step_command_controller_tb passed");
      end else begin
         $display("three_axis_step_command_controller_tb failed");
      end
      $finish;
   end

endmodule
